// ===== src/tilt_angle_kalman_filter_top_macros.svh =====
// assertion macros for the tilt filter
`ifndef TILT_ANGLE_KALMAN_FILTER_TOP_MACROS_SVH
`define TILT_ANGLE_KALMAN_FILTER_TOP_MACROS_SVH

// same-cycle implication
`define TAK_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tak assertion failed");

// next-cycle implication
`define TAK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tak assertion failed");

`endif

// ===== src/tak_pkg.sv =====
`default_nettype none
package tak_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int REG_W            = 31;
  localparam int IDX_W            = 8;

  localparam logic [REG_W-1:0] TIME_STEP_RST   = 31'd655;
  localparam logic [REG_W-1:0] MEAS_NOISE_RST  = 31'd19661;
  localparam logic [REG_W-1:0] ANGLE_NOISE_RST = 31'd66;
  localparam logic [REG_W-1:0] GYRO_NOISE_RST  = 31'd197;

  localparam logic [IDX_W-1:0] REG_TIME_STEP   = 8'd0;
  localparam logic [IDX_W-1:0] REG_MEAS_NOISE  = 8'd1;
  localparam logic [IDX_W-1:0] REG_ANGLE_NOISE = 8'd2;
  localparam logic [IDX_W-1:0] REG_GYRO_NOISE  = 8'd3;

  localparam logic signed [31:0] SAT_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

  localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] s);
    logic signed [31:0] r;
    if (s[32] != s[31]) r = s[32] ? SAT_MIN : SAT_MAX;
    else r = s[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] add_s(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    return sat33(s);
  endfunction

  function automatic logic signed [31:0] sub_s(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    return sat33(s);
  endfunction

  // atan(2^-i) in q30
  function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
    logic signed [35:0] r;
    unique case (i)
      5'd0:  r = 36'sd843314857;
      5'd1:  r = 36'sd497837829;
      5'd2:  r = 36'sd263043837;
      5'd3:  r = 36'sd133525159;
      5'd4:  r = 36'sd67021687;
      5'd5:  r = 36'sd33543516;
      5'd6:  r = 36'sd16775851;
      5'd7:  r = 36'sd8388437;
      5'd8:  r = 36'sd4194283;
      5'd9:  r = 36'sd2097149;
      5'd10: r = 36'sd1048576;
      5'd11: r = 36'sd524288;
      5'd12: r = 36'sd262144;
      5'd13: r = 36'sd131072;
      5'd14: r = 36'sd65536;
      5'd15: r = 36'sd32768;
      5'd16: r = 36'sd16384;
      5'd17: r = 36'sd8192;
      5'd18: r = 36'sd4096;
      5'd19: r = 36'sd2048;
      5'd20: r = 36'sd1024;
      5'd21: r = 36'sd512;
      5'd22: r = 36'sd256;
      5'd23: r = 36'sd128;
      5'd24: r = 36'sd64;
      default: r = 36'sd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/tak_mul.sv =====
`default_nettype none
module tak_mul #(
  parameter int FRAC_BITS = tak_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic signed [31:0]      y
);
  import tak_pkg::*;

  logic signed [63:0] prod;
  logic [63:0] mag;
  logic [63:0] m;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  // round half away from zero, then saturate
  always_comb begin
    mag = prod[63] ? 64'(-prod) : 64'(prod);
    m = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (prod[63]) begin
      if (m > 64'h80000000) y = SAT_MIN;
      else y = 32'(64'd0 - m);
    end else begin
      if (m > 64'h7FFFFFFF) y = SAT_MAX;
      else y = m[31:0];
    end
  end

endmodule
`default_nettype wire

// ===== src/tak_div.sv =====
`default_nettype none
module tak_div #(
  parameter int FRAC_BITS = tak_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [31:0] num,
  input  wire logic signed [31:0] den,
  output logic                    busy,
  output logic signed [31:0]      quo
);
  import tak_pkg::*;

  localparam int NB    = 32 + FRAC_BITS;
  localparam int CNT_W = $clog2(NB + 1);

  logic [NB-1:0]    sh;
  logic [31:0]      rem;
  logic [31:0]      dmag;
  logic             neg;
  logic [CNT_W-1:0] cnt;
  logic [32:0]      rem_sh;
  logic             ge;
  logic [31:0]      nmag;
  logic [NB-32:0]   hi;

  assign nmag   = num[31] ? 32'(-num) : 32'(num);
  assign rem_sh = {rem, sh[NB-1]};
  assign ge     = rem_sh >= {1'b0, dmag};
  assign hi     = sh[NB-1:31];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NB);
      sh   <= {nmag, {FRAC_BITS{1'b0}}};
      rem  <= '0;
      dmag <= den[31] ? 32'(-den) : 32'(den);
      neg  <= num[31] ^ den[31];
    end else if (busy) begin
      rem  <= ge ? 32'(rem_sh - {1'b0, dmag}) : rem_sh[31:0];
      sh   <= {sh[NB-2:0], ge};
      cnt  <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) busy <= 1'b0;
    end
  end

  always_comb begin
    if (neg) begin
      if (hi > (NB-31)'(1) || (hi == (NB-31)'(1) && sh[30:0] != '0)) quo = SAT_MIN;
      else quo = 32'(32'd0 - sh[31:0]);
    end else begin
      if (hi != '0) quo = SAT_MAX;
      else quo = sh[31:0];
    end
  end

endmodule
`default_nettype wire

// ===== src/tak_cordic.sv =====
`default_nettype none
module tak_cordic #(
  parameter int FRAC_BITS    = tak_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = tak_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [16:0] y_in,
  input  wire logic signed [15:0] x_in,
  output logic                    busy,
  output logic signed [31:0]      angle
);
  import tak_pkg::*;

  localparam int NSTEPS = (CORDIC_STEPS < 25) ? CORDIC_STEPS : 25;
  localparam int SH     = 30 - FRAC_BITS;

  logic signed [35:0] x, y, z;
  logic signed [35:0] xs, ys, x0, y0;
  logic [4:0]         i;
  logic               zero;
  logic [35:0]        zmag, m;

  assign x0 = 36'(x_in) <<< 16;
  assign y0 = 36'(y_in) <<< 16;
  assign xs = x >>> i;
  assign ys = y >>> i;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      i    <= '0;
    end else if (start) begin
      busy <= 1'b1;
      i    <= '0;
      zero <= (x_in == '0) && (y_in == '0);
      if (x_in[15]) begin
        x <= -x0;
        y <= -y0;
        z <= y_in[16] ? -PI_Q30 : PI_Q30;
      end else begin
        x <= x0;
        y <= y0;
        z <= '0;
      end
    end else if (busy) begin
      if (!y[35] && y != '0) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + atan_q30(i);
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - atan_q30(i);
      end
      i <= i + 1'b1;
      if (i == 5'(NSTEPS - 1)) busy <= 1'b0;
    end
  end

  // q30 to output format, ties away from zero
  always_comb begin
    zmag = z[35] ? 36'(-z) : 36'(z);
    m = (zmag + (36'd1 << (SH - 1))) >> SH;
    if (zero) angle = '0;
    else if (z[35]) angle = (m > 36'h80000000) ? SAT_MIN : 32'(36'd0 - m);
    else angle = (m > 36'h7FFFFFFF) ? SAT_MAX : m[31:0];
  end

endmodule
`default_nettype wire

// ===== src/tilt_angle_kalman_filter_top.sv =====
// tilt angle kalman filter: angle and gyro bias in signed fixed point
// input channel: in_valid/in_stall with action, gyro_rate, accel_x, accel_z.
// action 0 is a gyro predict word, action 1 an accelerometer correction word.
// output channel: out_valid/out_stall with angle, unbiased rate and bias;
// every input word gives exactly one output word.
// config: cfg_write with cfg_index and cfg_data; the user writes them only
// while idle; the block itself does not enforce this. one input word is
// held at a time; in_stall stays high until it is done. predict uses the
// one shared 32x32 multiplier for 4 products. a correction takes two gains
// from one bit-serial divider, with the cordic atan2 running alongside,
// then 6 products on the multiplier.
// the result sits in an output register; a stalled receiver holds it and
// the next word is taken meanwhile, but a new result waits for the old.
// reset gives identity covariance, zero angle, rate and bias, and default
// registers; it takes effect at the next clock edge.
`default_nettype none
`include "tilt_angle_kalman_filter_top_macros.svh"
module tilt_angle_kalman_filter_top #(
  parameter int FRAC_BITS    = tak_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = tak_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       action,
  input  wire logic signed [31:0]         gyro_rate,
  input  wire logic signed [15:0]         accel_x,
  input  wire logic signed [15:0]         accel_z,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [31:0]              angle_estimate,
  output logic signed [31:0]              rate_estimate,
  output logic signed [31:0]              bias_estimate,
  input  wire logic                       cfg_write,
  input  wire logic [tak_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [tak_pkg::REG_W-1:0]  cfg_data
);
  import tak_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PRE, ST_PM0, ST_PM1, ST_PM2, ST_PM3, ST_PM4,
    ST_UPD, ST_DIV0, ST_DIV1, ST_CWAIT,
    ST_UM0, ST_UM1, ST_UM2, ST_UM3, ST_UM4, ST_UM5, ST_UM6, ST_OUT
  } state_t;

  state_t state;

  logic [REG_W-1:0] time_step, measure_noise, angle_noise, gyro_noise;
  logic signed [31:0] dt, rn, qa, qg;

  logic signed [31:0] angle_reg, bias_reg, rate_reg;
  logic signed [31:0] p00, p01, p10, p11;
  logic signed [31:0] gyro_q;
  logic signed [15:0] ax_q, az_q;
  logic signed [31:0] ta, tb, tq, t0, t1, e, k0, k1, err;

  logic signed [31:0] ma, mb, my;
  logic signed [31:0] e_comb;
  logic               div_start, div_busy, cor_start, cor_busy;
  logic signed [31:0] div_n, div_d, div_q, meas;
  logic               in_acc, out_free;

  assign dt = $signed({1'b0, time_step});
  assign rn = $signed({1'b0, measure_noise});
  assign qa = $signed({1'b0, angle_noise});
  assign qg = $signed({1'b0, gyro_noise});

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign e_comb   = add_s(rn, p00);

  always_comb begin
    ma = tq;
    mb = dt;
    unique case (state)
      ST_PM1: ma = ta;
      ST_PM2: ma = tb;
      ST_PM3: ma = qg;
      ST_UM0: begin ma = k0; mb = t0; end
      ST_UM1: begin ma = k0; mb = t1; end
      ST_UM2: begin ma = k1; mb = t0; end
      ST_UM3: begin ma = k1; mb = t1; end
      ST_UM4: begin ma = k0; mb = err; end
      ST_UM5: begin ma = k1; mb = err; end
      default: begin ma = tq; mb = dt; end
    endcase
  end

  assign div_start = (state == ST_UPD && e_comb != '0) || (state == ST_DIV0 && !div_busy);
  assign div_n     = (state == ST_UPD) ? p00 : p10;
  assign div_d     = (state == ST_UPD) ? e_comb : e;
  assign cor_start = (state == ST_UPD);

  tak_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk (clk), .a (ma), .b (mb), .y (my)
  );

  tak_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk (clk), .rst (rst), .start (div_start), .num (div_n), .den (div_d),
    .busy (div_busy), .quo (div_q)
  );

  tak_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk (clk), .rst (rst), .start (cor_start),
    .y_in (17'sd0 - 17'(az_q)), .x_in (ax_q),
    .busy (cor_busy), .angle (meas)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      time_step     <= TIME_STEP_RST;
      measure_noise <= MEAS_NOISE_RST;
      angle_noise   <= ANGLE_NOISE_RST;
      gyro_noise    <= GYRO_NOISE_RST;
      angle_reg     <= '0;
      bias_reg      <= '0;
      rate_reg      <= '0;
      p00           <= 32'sd1 <<< FRAC_BITS;
      p01           <= '0;
      p10           <= '0;
      p11           <= 32'sd1 <<< FRAC_BITS;
    end else begin
      // in ST_OUT the load below decides out_valid
      if (out_valid && !out_stall && state != ST_OUT) out_valid <= 1'b0;
      if (cfg_write) begin
        if (cfg_index == REG_TIME_STEP) time_step <= cfg_data;
        if (cfg_index == REG_MEAS_NOISE) measure_noise <= cfg_data;
        if (cfg_index == REG_ANGLE_NOISE) angle_noise <= cfg_data;
        if (cfg_index == REG_GYRO_NOISE) gyro_noise <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            gyro_q <= gyro_rate;
            ax_q   <= accel_x;
            az_q   <= accel_z;
            state  <= action ? ST_UPD : ST_PRE;
          end
        end
        ST_PRE: begin
          tq       <= sub_s(gyro_q, bias_reg);
          rate_reg <= sub_s(gyro_q, bias_reg);
          ta       <= sub_s(sub_s(qa, p01), p10);
          tb       <= sub_s(32'sd0, p11);
          state    <= ST_PM0;
        end
        ST_PM0: state <= ST_PM1;
        ST_PM1: begin
          angle_reg <= add_s(angle_reg, my);
          state     <= ST_PM2;
        end
        ST_PM2: begin
          p00   <= add_s(p00, my);
          state <= ST_PM3;
        end
        ST_PM3: begin
          p01   <= add_s(p01, my);
          p10   <= add_s(p10, my);
          state <= ST_PM4;
        end
        ST_PM4: begin
          p11   <= add_s(p11, my);
          state <= ST_OUT;
        end
        ST_UPD: begin
          t0 <= p00;
          t1 <= p01;
          e  <= e_comb;
          if (e_comb != '0) begin
            state <= ST_DIV0;
          end else begin
            // no innovation variance: zero gains leave the state as is
            k0    <= '0;
            k1    <= '0;
            state <= ST_CWAIT;
          end
        end
        ST_DIV0: begin
          if (!div_busy) begin
            k0    <= div_q;
            state <= ST_DIV1;
          end
        end
        ST_DIV1: begin
          if (!div_busy) begin
            k1    <= div_q;
            state <= ST_CWAIT;
          end
        end
        ST_CWAIT: begin
          if (!cor_busy) begin
            err   <= sub_s(meas, angle_reg);
            state <= ST_UM0;
          end
        end
        ST_UM0: state <= ST_UM1;
        ST_UM1: begin
          p00   <= sub_s(p00, my);
          state <= ST_UM2;
        end
        ST_UM2: begin
          p01   <= sub_s(p01, my);
          state <= ST_UM3;
        end
        ST_UM3: begin
          p10   <= sub_s(p10, my);
          state <= ST_UM4;
        end
        ST_UM4: begin
          p11   <= sub_s(p11, my);
          state <= ST_UM5;
        end
        ST_UM5: begin
          angle_reg <= add_s(angle_reg, my);
          state     <= ST_UM6;
        end
        ST_UM6: begin
          bias_reg <= add_s(bias_reg, my);
          state    <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            angle_estimate <= angle_reg;
            rate_estimate  <= rate_reg;
            bias_estimate  <= bias_reg;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `TAK_ASSERT_NEXT(a_accept_starts, in_acc, state == ST_PRE || state == ST_UPD)
  `TAK_ASSERT_NEXT(a_out_loads, state == ST_OUT && out_free, out_valid && state == ST_IDLE)
  `TAK_ASSERT_IMPLY(a_units_done, state == ST_UM0, !div_busy && !cor_busy)

endmodule
`default_nettype wire
